[sv/ndt_pkg.sv]
// Shared constants and types for the name directory table.
// Sizes the table and its stored words; used by the top level and the RAM instance.
package ndt_pkg;

  localparam int ENTRIES      = 64;
  localparam int NAME_BYTES   = 8;

  localparam int NAME_W       = 64;               // packed name field on the port
  localparam int SECTOR_W     = 10;
  localparam int SLOT_OUT_W   = 6;                // slot field on the port
  localparam int STORE_NAME_W = 8 * NAME_BYTES;   // stored, normalized name
  localparam int ENTRY_W      = SECTOR_W + STORE_NAME_W;
  localparam int SLOT_W       = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    KIND_FIND   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

[sv/name_directory_table_top.sv]
// Name directory table: maps packed file names to header sectors in a table of
// ndt_pkg::ENTRIES slots. Depends on ndt_pkg and ndt_ram.
//
// Every request word (find, add, remove) yields one response word. A request is
// accepted, every slot of the name/sector RAM is then read in turn through its
// single read port while the previous read is checked, and the table is updated
// and the response register loaded once that register is free. A request is taken
// only in the idle state, not during a scan or while a result waits; a finished
// response waits in its own register, so the next request may start while it is
// still stalled. Valid marks live in flip-flops cleared by reset, so the table is
// usable right after reset with no clearing pass. The lowest matching valid slot
// answers find and remove; add fills the lowest free slot.
module name_directory_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [1:0]                     kind,
  input  logic [ndt_pkg::NAME_W-1:0]     file_name,
  input  logic [ndt_pkg::SECTOR_W-1:0]   header_sector,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [1:0]                     status,
  output logic [ndt_pkg::SECTOR_W-1:0]   found_sector,
  output logic [ndt_pkg::SLOT_OUT_W-1:0] slot
);
  import ndt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state;
  kind_t                   op;
  logic [STORE_NAME_W-1:0] name;
  logic [SECTOR_W-1:0]     sector;
  logic [CNT_W-1:0]        cnt;
  logic                    pend;
  logic [SLOT_W-1:0]       pidx;
  logic                    pvalid;
  logic                    hit;
  logic [SLOT_W-1:0]       hit_idx;
  logic [SECTOR_W-1:0]     hit_sector;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;
  logic [ENTRIES-1:0]      valid_bits;

  logic                    ram_we;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [STORE_NAME_W-1:0] rd_name;
  logic [SECTOR_W-1:0]     rd_sector;
  logic                    rsp_free;

  status_t                 status_next;
  logic [SECTOR_W-1:0]     found_sector_next;
  logic [SLOT_OUT_W-1:0]   slot_next;

  // Keep the low NAME_BYTES bytes; zero everything from the first zero byte on.
  function automatic logic [STORE_NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
    logic [STORE_NAME_W-1:0] o;
    logic                    stop;
    o    = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        o[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return o;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rd_name   = ram_rdata[STORE_NAME_W-1:0];
  assign rd_sector = ram_rdata[ENTRY_W-1:STORE_NAME_W];
  assign ram_we    = (state == S_DONE) && rsp_free && (op == KIND_ADD) && !hit && free_found;

  ndt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata ({sector, name}),
    .raddr (cnt[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    status_next       = ST_NOT_FOUND;
    found_sector_next = '0;
    slot_next         = '0;
    case (op)
      KIND_FIND: begin
        if (hit) begin
          status_next       = ST_OK;
          found_sector_next = hit_sector;
          slot_next         = SLOT_OUT_W'(hit_idx);
        end
      end
      KIND_ADD: begin
        if (hit) begin
          status_next = ST_DUPLICATE;
        end else if (free_found) begin
          status_next = ST_OK;
          slot_next   = SLOT_OUT_W'(free_idx);
        end else begin
          status_next = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          status_next = ST_OK;
          slot_next   = SLOT_OUT_W'(hit_idx);
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      valid_bits <= '0;
      pend       <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= kind_t'(kind);
            name       <= normalize(file_name);
            sector     <= header_sector;
            cnt        <= '0;
            pend       <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue the next read while the previous one is checked
          if (cnt < CNT_W'(ENTRIES)) begin
            pend   <= 1'b1;
            pidx   <= cnt[SLOT_W-1:0];
            pvalid <= valid_bits[cnt[SLOT_W-1:0]];
            cnt    <= cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (pvalid && (rd_name == name) && !hit) begin
              hit        <= 1'b1;
              hit_idx    <= pidx;
              hit_sector <= rd_sector;
            end
            if (!pvalid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pidx;
            end
            if (pidx == LAST_SLOT) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold until the response register is free
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            status       <= status_next;
            found_sector <= found_sector_next;
            slot         <= slot_next;
            if (ram_we) begin
              valid_bits[free_idx] <= 1'b1;
            end
            if ((op == KIND_REMOVE) && hit) begin
              valid_bits[hit_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ndt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; width and depth come from the parameters.
module ndt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
